// ----- rtl/object_track_table_update_unit_defines.svh -----
// Assertion macros for the object track table update unit.
`ifndef OBJECT_TRACK_TABLE_UPDATE_UNIT_DEFINES_SVH
`define OBJECT_TRACK_TABLE_UPDATE_UNIT_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define OTT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define OTT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/ott_pkg.sv -----
// Package with constants and types of the object track table update unit.
package ott_pkg;
  localparam int unsigned MaxTracks = 32;
  localparam logic [2:0] StUpdated = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StDropOverlap = 3'd2;
  localparam logic [2:0] StDropFull = 3'd3;
  localparam logic [2:0] StCleanup = 3'd4;
  localparam logic [1:0] RegOverlap = 2'd0;
  localparam logic [1:0] RegStale = 2'd1;
  localparam logic [1:0] RegDeadzone = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] object_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic [5:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [31:0] seen;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic signed [34:0] num;
    logic [31:0] den;
  } div_req_t;

  function automatic logic near_axis(logic signed [23:0] a, logic signed [23:0] b,
                                     logic [22:0] lim);
    logic signed [24:0] d;
    d = 25'(a) - 25'(b);
    if (d < 0) d = -d;
    return d <= $signed({2'b0, lim});
  endfunction
endpackage

// ----- rtl/ott_if.sv -----
// Valid/ready channel interface carrying one item.
interface ott_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ott_div.sv -----
// Sequential signed divider for the velocity quotient with deadzone and saturation.
module ott_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ott_pkg::div_req_t  req_i,
  input  logic [22:0]        deadzone_i,
  output logic               done_o,
  output logic signed [23:0] vel_o
);
  logic [34:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] den_q;
  logic        neg_q, busy_q;
  logic [5:0]  cnt_q;
  logic [35:0] trial;
  logic [34:0] mag;
  logic signed [35:0] v;
  logic [35:0] vabs;

  always_comb begin
    trial = {rem_q, quo_q[34]} - {4'b0, den_q};
    rem_d = trial[35] ? {rem_q[33:0], quo_q[34]} : trial[34:0];
    quo_d = {quo_q[33:0], ~trial[35]};
    mag = req_i.num[34] ? 35'(-req_i.num) : 35'(req_i.num);
    v = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    vabs = {1'b0, quo_q};
    if (den_q == '0) vel_o = '0;
    else if (vabs < 36'(deadzone_i)) vel_o = '0;
    else if (v > 36'sd8388607) vel_o = 24'sh7fffff;
    else if (v < -36'sd8388608) vel_o = 24'sh800000;
    else vel_o = v[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd35;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= mag;
      den_q <= req_i.den;
      neg_q <= req_i.num[34];
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end
endmodule

// ----- rtl/object_track_table_update_unit.sv -----
// Object track table update unit: top level with table memory and control.
// An item walks the table through a synchronous memory with a registered
// read. A detection scans the entries until it matches or overlaps one;
// else it inserts or is dropped as full. A match runs the two 35-step
// dividers in parallel. Frame-end cleanup compares each entry against
// the kept entries before it. Results leave through an output register;
// the next item is taken once the current result has been accepted.
`include "object_track_table_update_unit_defines.svh"
module object_track_table_update_unit #(
  parameter int unsigned MAX_TRACKS = ott_pkg::MaxTracks,
  localparam int unsigned Aw = $clog2(MAX_TRACKS),
  localparam int unsigned Cw = $clog2(MAX_TRACKS + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ott_if.sink         in_if,
  ott_if.source       out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] SIdle = 4'd0, SScan = 4'd1, SScanChk = 4'd2, SDiv = 4'd3,
    SOut = 4'd4, SCi = 4'd5, SCiChk = 4'd6, SCj = 4'd7, SCjChk = 4'd8, SCkeep = 4'd9;

  logic [22:0] overlap_q, deadzone_q;
  logic [31:0] stale_q;
  logic [3:0]  st_q;
  logic [Cw-1:0] total_q, i_q, j_q, kept_q;
  ott_pkg::in_item_t it_q;
  ott_pkg::entry_t   mem [MAX_TRACKS];
  ott_pkg::entry_t   rd_q, ent_i_q;
  logic [Aw-1:0]     raddr;
  logic              we;
  logic [Aw-1:0]     waddr;
  ott_pkg::entry_t   wdata;
  ott_pkg::out_item_t res_q;
  logic              out_valid_q;
  ott_pkg::div_req_t dreq_x, dreq_y;
  logic              dx_done, dy_done;
  logic signed [23:0] vx, vy;
  logic [31:0]       dt;
  logic [31:0]       age;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      ott_pkg::RegOverlap:  prdata = {9'b0, overlap_q};
      ott_pkg::RegStale:    prdata = stale_q;
      ott_pkg::RegDeadzone: prdata = {9'b0, deadzone_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overlap_q  <= 23'd128;
      stale_q    <= 32'd1000;
      deadzone_q <= 23'd26;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ott_pkg::RegOverlap:  overlap_q <= pwdata[22:0];
        ott_pkg::RegStale:    stale_q <= pwdata;
        ott_pkg::RegDeadzone: deadzone_q <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready  = (st_q == SIdle) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign dt  = it_q.now_ms - rd_q.seen;
  assign age = it_q.now_ms - ent_i_q.seen;

  always_comb begin
    dreq_x.start = (st_q == SScanChk) && (rd_q.id == it_q.object_id);
    dreq_x.num = (35'(it_q.pos_x) - 35'(rd_q.x)) * 35'sd1000;
    dreq_x.den = dt;
    dreq_y.start = dreq_x.start;
    dreq_y.num = (35'(it_q.pos_y) - 35'(rd_q.y)) * 35'sd1000;
    dreq_y.den = dt;
  end

  ott_div u_div_x (.clk_i, .rst_ni, .req_i(dreq_x), .deadzone_i(deadzone_q),
                   .done_o(dx_done), .vel_o(vx));
  ott_div u_div_y (.clk_i, .rst_ni, .req_i(dreq_y), .deadzone_i(deadzone_q),
                   .done_o(dy_done), .vel_o(vy));

  always_comb begin
    raddr = i_q[Aw-1:0];
    we = 1'b0;
    waddr = i_q[Aw-1:0];
    wdata = rd_q;
    case (st_q)
      SCi:  raddr = i_q[Aw-1:0];
      SCj:  raddr = j_q[Aw-1:0];
      SDiv: begin
        we = dx_done && dy_done;
        wdata.id = it_q.object_id;
        wdata.x = it_q.pos_x;
        wdata.y = it_q.pos_y;
        wdata.vx = vx;
        wdata.vy = vy;
        wdata.seen = it_q.now_ms;
      end
      SScan: begin
        if (i_q >= total_q && total_q < Cw'(MAX_TRACKS)) begin
          we = 1'b1;
          wdata.id = it_q.object_id;
          wdata.x = it_q.pos_x;
          wdata.y = it_q.pos_y;
          wdata.vx = '0;
          wdata.vy = '0;
          wdata.seen = it_q.now_ms;
        end
      end
      SCkeep: begin
        we = (kept_q != i_q);
        waddr = kept_q[Aw-1:0];
        wdata = ent_i_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      total_q <= '0;
      i_q <= '0;
      j_q <= '0;
      kept_q <= '0;
      out_valid_q <= 1'b0;
      res_q <= '0;
      ent_i_q <= '0;
    end else begin
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      case (st_q)
        SIdle: if (in_if.valid && in_if.ready) begin
          i_q <= '0;
          kept_q <= '0;
          st_q <= in_if.data.opcode ? SCi : SScan;
        end
        SScan: begin
          if (i_q >= total_q) begin
            res_q.vel_x <= '0;
            res_q.vel_y <= '0;
            if (total_q < Cw'(MAX_TRACKS)) begin
              res_q.status <= ott_pkg::StInserted;
              res_q.slot <= 5'(i_q);
              res_q.entry_count <= 6'(total_q + Cw'(1));
              total_q <= total_q + Cw'(1);
            end else begin
              res_q.status <= ott_pkg::StDropFull;
              res_q.slot <= '0;
              res_q.entry_count <= 6'(total_q);
            end
            st_q <= SOut;
          end else st_q <= SScanChk;
        end
        SScanChk: begin
          res_q.slot <= 5'(i_q);
          res_q.entry_count <= 6'(total_q);
          res_q.vel_x <= '0;
          res_q.vel_y <= '0;
          if (rd_q.id == it_q.object_id) begin
            res_q.status <= ott_pkg::StUpdated;
            st_q <= SDiv;
          end else if (ott_pkg::near_axis(rd_q.x, it_q.pos_x, overlap_q) &&
                       ott_pkg::near_axis(rd_q.y, it_q.pos_y, overlap_q)) begin
            res_q.status <= ott_pkg::StDropOverlap;
            st_q <= SOut;
          end else begin
            i_q <= i_q + Cw'(1);
            st_q <= SScan;
          end
        end
        SDiv: if (dx_done && dy_done) begin
          res_q.vel_x <= vx;
          res_q.vel_y <= vy;
          st_q <= SOut;
        end
        SOut: begin
          out_valid_q <= 1'b1;
          st_q <= SIdle;
        end
        SCi: begin
          if (i_q >= total_q) begin
            total_q <= kept_q;
            res_q <= '{status: ott_pkg::StCleanup, slot: '0, vel_x: '0, vel_y: '0,
                       entry_count: 6'(kept_q)};
            st_q <= SOut;
          end else st_q <= SCiChk;
        end
        SCiChk: begin
          ent_i_q <= rd_q;
          j_q <= '0;
          st_q <= SCj;
        end
        SCj: begin
          if (j_q >= kept_q) st_q <= SCkeep;
          else st_q <= SCjChk;
        end
        SCjChk: begin
          if (ott_pkg::near_axis(ent_i_q.x, rd_q.x, overlap_q) &&
              ott_pkg::near_axis(ent_i_q.y, rd_q.y, overlap_q)) begin
            i_q <= i_q + Cw'(1);
            st_q <= SCi;
          end else begin
            j_q <= j_q + Cw'(1);
            st_q <= SCj;
          end
        end
        SCkeep: begin
          if (age <= stale_q) kept_q <= kept_q + Cw'(1);
          i_q <= i_q + Cw'(1);
          st_q <= SCi;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) it_q <= in_if.data;
  end

  `OTT_ASSERT_IMPL(a_total_bound, clk_i, rst_ni, 1'b1, total_q <= Cw'(MAX_TRACKS))
  `OTT_ASSERT_IMPL(a_kept_le_i, clk_i, rst_ni, st_q == SCi, kept_q <= i_q)
  `OTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_if.ready,
                   out_valid_q && $stable(res_q))
  `OTT_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, st_q != SIdle, !in_if.ready)
endmodule
